// ===== sv/sdq_pkg.sv =====
// Shared types and constants for the sleep delta queue.
// Used by sdq_cell, sdq_rsp_reg and sleep_delta_queue; depends on nothing.
`default_nettype none

package sdq_pkg;

   // Default sizes for the top-level parameters.
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT   = 16;

   // Fixed field widths of the request and response beats.
   localparam int CMD_BITS   = 2;
   localparam int ID_BITS    = 8;
   localparam int TICKS_BITS = 16;
   localparam int KIND_BITS  = 3;

   // Request commands.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT = 2'd0,
      CMD_TICK   = 2'd1,
      CMD_WAKE   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   // Response kinds.
   typedef enum logic [KIND_BITS-1:0] {
      KIND_ACCEPTED = 3'd0,
      KIND_IGNORED  = 3'd1,
      KIND_FULL     = 3'd2,
      KIND_WOKEN    = 3'd3,
      KIND_NONE     = 3'd4,
      KIND_CLEARED  = 3'd5
   } kind_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic shift;   // take the neighbor's entry
      logic clear;   // drop the entry
      logic dec;     // decrement the stored delta
   } cell_ctrl_type;

   // Response fields that do not depend on the queue depth.
   typedef struct packed {
      kind_type               kind;
      logic [ID_BITS-1:0]     woken_id;
      logic                   last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/sleep_delta_queue.sv =====
// Sleep delta queue: a chain of QUEUE_DEPTH cells holding thread ids in wake order.
// Insert rotates the whole chain once through a placement stage.
// Tick counts the head down, then releases due entries one response beat at a time;
// wake all releases every entry in order. Clear, ignored and rejected requests
// give a single status beat. One request is handled at a time; a stalled beat holds it.
// Synchronous active-high reset empties the queue and drops any pending response.
`default_nettype none

module sleep_delta_queue #(
   parameter int QUEUE_DEPTH = sdq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TIME_BITS   = sdq_pkg::TIME_BITS_DEFAULT,
   localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [sdq_pkg::CMD_BITS-1:0]     req_cmd,
   input  wire logic [sdq_pkg::ID_BITS-1:0]      req_thread_id,
   input  wire logic [sdq_pkg::TICKS_BITS-1:0]   req_sleep_ticks,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [sdq_pkg::KIND_BITS-1:0]         rsp_kind,
   output logic [sdq_pkg::ID_BITS-1:0]           rsp_woken_id,
   output logic [CNT_BITS-1:0]                   rsp_entries_left,
   output logic                                  rsp_last
);

   localparam int STEP_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_WALK = 6'b000010,
      S_TDEC = 6'b000100,
      S_TPOP = 6'b001000,
      S_WAKE = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_BITS-1:0]          count_ff, count_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic                         placed_ff, placed_in;
   sdq_pkg::kind_type            kind_ff, kind_in;
   logic [TIME_BITS-1:0]         rem_ff, rem_in;
   logic [sdq_pkg::ID_BITS-1:0]  new_id_ff, new_id_in;
   logic                         carry_valid_ff, carry_valid_in;
   logic [sdq_pkg::ID_BITS-1:0]  carry_id_ff, carry_id_in;
   logic [TIME_BITS-1:0]         carry_delta_ff, carry_delta_in;

   logic                         cell_valid [QUEUE_DEPTH];
   logic [sdq_pkg::ID_BITS-1:0]  cell_id    [QUEUE_DEPTH];
   logic [TIME_BITS-1:0]         cell_delta [QUEUE_DEPTH];

   logic                         tail_valid;
   logic [sdq_pkg::ID_BITS-1:0]  tail_id;
   logic [TIME_BITS-1:0]         tail_delta;

   logic                         shift_en, clear_en, dec_en;
   logic                         emit;
   sdq_pkg::rsp_type             emit_rsp;
   logic [CNT_BITS-1:0]          emit_count;
   logic                         slot_free;
   logic [TIME_BITS-1:0]         req_time;
   logic                         head_due, next_due;

   assign req_ready = (state_ff == S_IDLE);
   assign req_time  = TIME_BITS'(req_sleep_ticks);
   assign head_due  = cell_valid[0] && (cell_delta[0] == '0);
   assign next_due  = cell_valid[1] && (cell_delta[1] == '0);

   // Chain of cells; each takes from the one behind it, the last from the tail feed.
   for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
      sdq_pkg::cell_ctrl_type ctrl;
      logic                        nbr_valid;
      logic [sdq_pkg::ID_BITS-1:0] nbr_id;
      logic [TIME_BITS-1:0]        nbr_delta;

      assign ctrl.shift = shift_en;
      assign ctrl.clear = clear_en;
      assign ctrl.dec   = (k == 0) ? dec_en : 1'b0;

      if (k == QUEUE_DEPTH - 1) begin : g_tail
         assign nbr_valid = tail_valid;
         assign nbr_id    = tail_id;
         assign nbr_delta = tail_delta;
      end else begin : g_mid
         assign nbr_valid = cell_valid[k+1];
         assign nbr_id    = cell_id[k+1];
         assign nbr_delta = cell_delta[k+1];
      end

      sdq_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .nbr_valid (nbr_valid),
         .nbr_id    (nbr_id),
         .nbr_delta (nbr_delta),
         .valid     (cell_valid[k]),
         .id        (cell_id[k]),
         .delta     (cell_delta[k])
      );
   end

   // Sequencer: request decode, insert walk, and the release loops.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      placed_in      = placed_ff;
      kind_in        = kind_ff;
      rem_in         = rem_ff;
      new_id_in      = new_id_ff;
      carry_valid_in = carry_valid_ff;
      carry_id_in    = carry_id_ff;
      carry_delta_in = carry_delta_ff;
      tail_valid     = 1'b0;
      tail_id        = '0;
      tail_delta     = '0;
      shift_en       = 1'b0;
      clear_en       = 1'b0;
      dec_en         = 1'b0;
      emit           = 1'b0;
      emit_rsp.kind     = kind_ff;
      emit_rsp.woken_id = '0;
      emit_rsp.last     = 1'b1;
      emit_count     = count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (sdq_pkg::cmd_type'(req_cmd))
                  sdq_pkg::CMD_INSERT: begin
                     if (req_time == '0) begin
                        kind_in  = sdq_pkg::KIND_IGNORED;
                        state_in = S_RESP;
                     end else if (count_ff == CNT_BITS'(QUEUE_DEPTH)) begin
                        kind_in  = sdq_pkg::KIND_FULL;
                        state_in = S_RESP;
                     end else begin
                        rem_in    = req_time;
                        new_id_in = req_thread_id;
                        placed_in = 1'b0;
                        step_in   = '0;
                        state_in  = S_WALK;
                     end
                  end
                  sdq_pkg::CMD_TICK: begin
                     if (count_ff == '0) begin
                        kind_in  = sdq_pkg::KIND_NONE;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_TDEC;
                     end
                  end
                  sdq_pkg::CMD_WAKE: begin
                     if (count_ff == '0) begin
                        kind_in  = sdq_pkg::KIND_NONE;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_WAKE;
                     end
                  end
                  sdq_pkg::CMD_CLEAR: begin
                     clear_en = 1'b1;
                     count_in = '0;
                     kind_in  = sdq_pkg::KIND_CLEARED;
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // Rotate the chain once; the new entry goes in ahead of the first
         // entry that is empty or not shorter than the remaining time.
         S_WALK: begin
            shift_en = 1'b1;
            if (!placed_ff) begin
               if (!cell_valid[0] || (cell_delta[0] >= rem_ff)) begin
                  tail_valid     = 1'b1;
                  tail_id        = new_id_ff;
                  tail_delta     = rem_ff;
                  carry_valid_in = cell_valid[0];
                  carry_id_in    = cell_id[0];
                  carry_delta_in = cell_delta[0] - rem_ff;
                  placed_in      = 1'b1;
               end else begin
                  tail_valid = cell_valid[0];
                  tail_id    = cell_id[0];
                  tail_delta = cell_delta[0];
                  rem_in     = rem_ff - cell_delta[0];
               end
            end else begin
               tail_valid     = carry_valid_ff;
               tail_id        = carry_id_ff;
               tail_delta     = carry_delta_ff;
               carry_valid_in = cell_valid[0];
               carry_id_in    = cell_id[0];
               carry_delta_in = cell_delta[0];
            end
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(QUEUE_DEPTH - 1)) begin
               count_in = count_ff + CNT_BITS'(1);
               kind_in  = sdq_pkg::KIND_ACCEPTED;
               state_in = S_RESP;
            end
         end

         // The head counts down one tick unless it is already due.
         S_TDEC: begin
            dec_en   = (cell_delta[0] != '0);
            state_in = S_TPOP;
         end

         // Release due head entries, one beat per cycle while the slot is free.
         S_TPOP: begin
            if (slot_free) begin
               emit = 1'b1;
               if (head_due) begin
                  shift_en          = 1'b1;
                  count_in          = count_ff - CNT_BITS'(1);
                  emit_count        = count_ff - CNT_BITS'(1);
                  emit_rsp.kind     = sdq_pkg::KIND_WOKEN;
                  emit_rsp.woken_id = cell_id[0];
                  emit_rsp.last     = !next_due;
                  if (!next_due) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  emit_rsp.kind = sdq_pkg::KIND_NONE;
                  state_in      = S_IDLE;
               end
            end
         end

         // Release every entry in order.
         S_WAKE: begin
            if (slot_free) begin
               emit              = 1'b1;
               shift_en          = 1'b1;
               count_in          = count_ff - CNT_BITS'(1);
               emit_count        = count_ff - CNT_BITS'(1);
               emit_rsp.kind     = sdq_pkg::KIND_WOKEN;
               emit_rsp.woken_id = cell_id[0];
               emit_rsp.last     = !cell_valid[1];
               if (!cell_valid[1]) begin
                  state_in = S_IDLE;
               end
            end
         end

         // Single status beat for the request.
         S_RESP: begin
            if (slot_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      placed_ff      <= placed_in;
      kind_ff        <= kind_in;
      rem_ff         <= rem_in;
      new_id_ff      <= new_id_in;
      carry_valid_ff <= carry_valid_in;
      carry_id_ff    <= carry_id_in;
      carry_delta_ff <= carry_delta_in;
   end

   // Response register.
   sdq_rsp_reg #(
      .CNT_BITS (CNT_BITS)
   ) u_rsp (
      .clock            (clock),
      .reset            (reset),
      .load             (emit),
      .rsp_in           (emit_rsp),
      .count_in         (emit_count),
      .slot_free        (slot_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_woken_id     (rsp_woken_id),
      .rsp_entries_left (rsp_entries_left),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sv/sdq_cell.sv =====
// One cell of the delta queue chain: an occupancy flag, a thread id and a
// relative delta. Depends on sdq_pkg.
`default_nettype none

module sdq_cell #(
   parameter int TIME_BITS = sdq_pkg::TIME_BITS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sdq_pkg::cell_ctrl_type      ctrl,
   input  wire logic                        nbr_valid,
   input  wire logic [sdq_pkg::ID_BITS-1:0] nbr_id,
   input  wire logic [TIME_BITS-1:0]        nbr_delta,
   output logic                             valid,
   output logic [sdq_pkg::ID_BITS-1:0]      id,
   output logic [TIME_BITS-1:0]             delta
);

   logic                        valid_ff, valid_in;
   logic [sdq_pkg::ID_BITS-1:0] id_ff, id_in;
   logic [TIME_BITS-1:0]        delta_ff, delta_in;

   // Next entry: clear, take from the neighbor, or decrement in place.
   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      delta_in = delta_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in = nbr_valid;
         id_in    = nbr_id;
         delta_in = nbr_delta;
      end else if (ctrl.dec) begin
         delta_in = delta_ff - TIME_BITS'(1);
      end
   end

   // Occupancy resets; the payload does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      delta_ff <= delta_in;
   end

   assign valid = valid_ff;
   assign id    = id_ff;
   assign delta = delta_ff;

endmodule

`default_nettype wire

// ===== sv/sdq_rsp_reg.sv =====
// Response output register of the sleep delta queue with valid/ready.
// Depends on sdq_pkg.
`default_nettype none

module sdq_rsp_reg #(
   parameter int CNT_BITS = 5
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire sdq_pkg::rsp_type              rsp_in,
   input  wire logic [CNT_BITS-1:0]           count_in,
   output logic                               slot_free,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [sdq_pkg::KIND_BITS-1:0]      rsp_kind,
   output logic [sdq_pkg::ID_BITS-1:0]        rsp_woken_id,
   output logic [CNT_BITS-1:0]                rsp_entries_left,
   output logic                               rsp_last
);

   logic                  valid_ff, valid_in;
   sdq_pkg::rsp_type      data_ff;
   logic [CNT_BITS-1:0]   count_ff;

   // The slot can take a new beat when empty or when it drains this cycle.
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff  <= rsp_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = data_ff.kind;
   assign rsp_woken_id     = data_ff.woken_id;
   assign rsp_entries_left = count_ff;
   assign rsp_last         = data_ff.last;

endmodule

`default_nettype wire
